>>> hdl/kmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the k-means clustering engine.
// ----------------------------------------------------------------------------
package kmc_pkg;

	localparam int MAX_POINTS_DEF   = 1024;
	localparam int DIMENSIONS_DEF   = 4;
	localparam int MAX_CLUSTERS_DEF = 8;

	localparam int COORD_W = 16;
	localparam int THR_W   = 40;

	// command codes
	typedef enum logic [1:0] {
		CMD_LOAD_CENT  = 2'd0,
		CMD_LOAD_POINT = 2'd1,
		CMD_RUN        = 2'd2,
		CMD_READ       = 2'd3
	} cmd_t;

	// register indexes
	localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd0;
	localparam logic [1:0] CFG_MAX_ITER     = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

	localparam logic [3:0]       NUM_CLUSTERS_RST = 4'd8;
	localparam logic [7:0]       MAX_ITER_RST     = 8'd100;
	localparam logic [THR_W-1:0] THRESHOLD_RST    = 40'd6553600;

	typedef struct packed {
		cmd_t                      command;
		logic signed [COORD_W-1:0] value;
		logic [9:0]                point_index;
		logic                      last_point;
	} item_t;

	typedef struct packed {
		logic [2:0] label;
		logic [7:0] iterations_used;
		logic       converged;
	} result_t;

	// per-iteration controls sent to every cell
	typedef struct packed {
		logic clear;
		logic div_start;
		logic update;
	} ctl_t;

endpackage

>>> hdl/kmeans_clustering_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_clustering_engine
// Lloyd k-means in Q8.8 over loaded points, one chain cell per cluster.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                     | word
//  command   | in        | start, busy                   | item (item_t)
//  result    | out       | result_valid strobe, no stall | result (result_t)
//  config    | in        | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
//  Load commands stream back to back; a read holds busy while in S_READ.
//  A run, per iteration, streams the points through the cell chain, waits
//  for the chain to drain, runs the per-cell serial divider and sums the
//  shift along the chain; busy stays high meanwhile.
//  Reset presets control state and config registers; no stores are cleared.
// ----------------------------------------------------------------------------
module kmeans_clustering_engine #(
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
	parameter int DIMENSIONS   = kmc_pkg::DIMENSIONS_DEF,
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  kmc_pkg::item_t             item,
	output logic                       result_valid,
	output kmc_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [kmc_pkg::THR_W-1:0]  cfg_data
);

	localparam int PSIZE  = MAX_POINTS * DIMENSIONS;
	localparam int DIM_W  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int IDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int PA_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PC_W   = $clog2(MAX_POINTS + 1);
	localparam int MA_W   = (PSIZE > 1) ? $clog2(PSIZE) : 1;
	localparam int LP_W   = $clog2(PSIZE + 1);
	localparam int CNT_W  = PC_W;
	localparam int SUM_W  = 16 + CNT_W;
	localparam int DIST_W = 32 + $clog2(DIMENSIONS) + 1;
	localparam int SH_W   = 32 + $clog2(DIMENSIONS) + $clog2(MAX_CLUSTERS) + 1;
	localparam int CMP_W  = (SH_W > kmc_pkg::THR_W) ? SH_W : kmc_pkg::THR_W;
	localparam int DRAIN  = 3 * MAX_CLUSTERS + 6;
	localparam int SHCYC  = MAX_CLUSTERS + 2;
	localparam int WT_W   = $clog2(DRAIN + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_CLEAR, S_ASSIGN, S_DRAIN, S_DIV, S_SHIFT, S_DECIDE
	} state_t;

	state_t                    state_q;
	logic [3:0]                num_q;
	logic [7:0]                maxit_q;
	logic [kmc_pkg::THR_W-1:0] thr_q;
	logic                      accept;

	logic signed [15:0]        point_mem [PSIZE];
	logic [IDX_W-1:0]          label_mem [MAX_POINTS];

	logic [LP_W-1:0]           lp_q, lp_next;
	logic [DIM_W-1:0]          lp_dim_q, lp_dim_next;
	logic [PC_W-1:0]           lp_pt_q, lp_pt_next, pcount_q;
	logic                      lp_room;
	logic [IDX_W-1:0]          cp_cell_q;
	logic [DIM_W-1:0]          cp_dim_q;
	logic                      ld_v;

	logic [LP_W-1:0]           rd_q, total;
	logic [DIM_W-1:0]          rd_dim_q;
	logic                      iss_v_q, iss_last_q;
	logic [DIM_W-1:0]          iss_dim_q;
	logic signed [15:0]        pm_q;
	logic [WT_W-1:0]           wait_q;
	logic [7:0]                iter_q, iter_next;
	logic                      conv_q;
	kmc_pkg::ctl_t             ctl_q;
	logic                      res_v_q;
	kmc_pkg::result_t          res_q;
	logic [IDX_W-1:0]          lbl_rd_q;
	logic                      in_range_q;

	logic                      ch_v    [MAX_CLUSTERS+1];
	logic signed [15:0]        ch_x    [MAX_CLUSTERS+1];
	logic [DIM_W-1:0]          ch_dim  [MAX_CLUSTERS+1];
	logic                      ch_last [MAX_CLUSTERS+1];
	logic [DIST_W-1:0]         ch_bd   [MAX_CLUSTERS+1];
	logic [IDX_W-1:0]          ch_bi   [MAX_CLUSTERS+1];
	logic [SH_W-1:0]           ch_sh   [MAX_CLUSTERS+1];
	logic [MAX_CLUSTERS-1:0]   cell_en, cell_done;

	logic signed [15:0]        win_q [DIMENSIONS];
	logic                      bc_v_q;
	logic [IDX_W-1:0]          bc_idx_q;
	logic [DIMENSIONS*16-1:0]  bc_x;
	logic [PA_W-1:0]           wr_pt_q;
	logic                      shift_ok;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= kmc_pkg::NUM_CLUSTERS_RST;
			maxit_q <= kmc_pkg::MAX_ITER_RST;
			thr_q   <= kmc_pkg::THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kmc_pkg::CFG_NUM_CLUSTERS: num_q   <= cfg_data[3:0];
				kmc_pkg::CFG_MAX_ITER:     maxit_q <= cfg_data[7:0];
				kmc_pkg::CFG_THRESHOLD:    thr_q   <= cfg_data;
				default:                   num_q   <= num_q;
			endcase
		end
	end

	// point load position
	assign lp_room     = (lp_q < LP_W'(PSIZE));
	assign lp_next     = lp_room ? lp_q + 1'b1 : lp_q;
	assign lp_dim_next = !lp_room ? lp_dim_q :
		(lp_dim_q == DIM_W'(DIMENSIONS - 1)) ? '0 : lp_dim_q + 1'b1;
	assign lp_pt_next  = (lp_room && lp_dim_q == DIM_W'(DIMENSIONS - 1)) ?
		lp_pt_q + 1'b1 : lp_pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q      <= '0;
			lp_dim_q  <= '0;
			lp_pt_q   <= '0;
			pcount_q  <= '0;
			cp_cell_q <= '0;
			cp_dim_q  <= '0;
		end else if (accept) begin
			unique case (item.command)
				kmc_pkg::CMD_LOAD_POINT: begin
					if (item.last_point) begin
						pcount_q <= lp_pt_next + PC_W'(lp_dim_next != '0);
						lp_q     <= '0;
						lp_dim_q <= '0;
						lp_pt_q  <= '0;
					end else begin
						lp_q     <= lp_next;
						lp_dim_q <= lp_dim_next;
						lp_pt_q  <= lp_pt_next;
					end
				end
				kmc_pkg::CMD_LOAD_CENT: begin
					if (cp_dim_q == DIM_W'(DIMENSIONS - 1)) begin
						cp_dim_q  <= '0;
						cp_cell_q <= (cp_cell_q == IDX_W'(MAX_CLUSTERS - 1)) ?
							'0 : cp_cell_q + 1'b1;
					end else begin
						cp_dim_q <= cp_dim_q + 1'b1;
					end
				end
				kmc_pkg::CMD_RUN: begin
					cp_cell_q <= '0;
					cp_dim_q  <= '0;
				end
				kmc_pkg::CMD_READ: begin
					cp_dim_q <= cp_dim_q;
				end
				default: cp_dim_q <= cp_dim_q;
			endcase
		end
	end

	assign ld_v  = accept && item.command == kmc_pkg::CMD_LOAD_CENT;
	assign total = LP_W'(32'(pcount_q) * DIMENSIONS);

	// point memory: write on load, stream out during assignment
	always_ff @(posedge clk) begin
		if (accept && item.command == kmc_pkg::CMD_LOAD_POINT && lp_room) begin
			point_mem[lp_q[MA_W-1:0]] <= item.value;
		end
		pm_q       <= point_mem[rd_q[MA_W-1:0]];
		iss_dim_q  <= rd_dim_q;
		iss_last_q <= (rd_dim_q == DIM_W'(DIMENSIONS - 1));
	end

	// label memory: write from the chain tail, read for read commands
	always_ff @(posedge clk) begin
		if (bc_v_q) begin
			label_mem[wr_pt_q] <= bc_idx_q;
		end
		lbl_rd_q   <= label_mem[PA_W'(32'(item.point_index))];
		in_range_q <= (32'(item.point_index) < MAX_POINTS);
	end

	// chain of cluster cells
	assign ch_v[0]    = iss_v_q;
	assign ch_x[0]    = pm_q;
	assign ch_dim[0]  = iss_dim_q;
	assign ch_last[0] = iss_last_q;
	assign ch_bd[0]   = '1;
	assign ch_bi[0]   = '0;
	assign ch_sh[0]   = '0;

	for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
		assign cell_en[c] = (c == 0) || ({28'd0, num_q} > 32'(c));
		kmc_cell #(
			.DIMENSIONS (DIMENSIONS),
			.CELL_ID    (c),
			.IDX_W      (IDX_W),
			.DIM_W      (DIM_W),
			.DIST_W     (DIST_W),
			.CNT_W      (CNT_W),
			.SUM_W      (SUM_W),
			.SH_W       (SH_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_q),
			.en       (cell_en[c]),
			.ld_v     (ld_v),
			.ld_cell  (cp_cell_q),
			.ld_dim   (cp_dim_q),
			.ld_x     (item.value),
			.v_in     (ch_v[c]),
			.x_in     (ch_x[c]),
			.dim_in   (ch_dim[c]),
			.last_in  (ch_last[c]),
			.bd_in    (ch_bd[c]),
			.bi_in    (ch_bi[c]),
			.v_out    (ch_v[c+1]),
			.x_out    (ch_x[c+1]),
			.dim_out  (ch_dim[c+1]),
			.last_out (ch_last[c+1]),
			.bd_out   (ch_bd[c+1]),
			.bi_out   (ch_bi[c+1]),
			.bc_v     (bc_v_q),
			.bc_idx   (bc_idx_q),
			.bc_x     (bc_x),
			.sh_in    (ch_sh[c]),
			.sh_out   (ch_sh[c+1]),
			.done     (cell_done[c])
		);
	end

	// hold the last coordinates at the chain tail for the broadcast
	always_ff @(posedge clk) begin
		if (ch_v[MAX_CLUSTERS]) begin
			win_q[0] <= ch_x[MAX_CLUSTERS];
			for (int j = 1; j < DIMENSIONS; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
		bc_idx_q <= ch_bi[MAX_CLUSTERS];
	end

	for (genvar d = 0; d < DIMENSIONS; d++) begin : g_bc
		assign bc_x[d*16 +: 16] = win_q[DIMENSIONS-1-d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_v_q  <= 1'b0;
			wr_pt_q <= '0;
		end else begin
			bc_v_q <= ch_v[MAX_CLUSTERS] && ch_last[MAX_CLUSTERS];
			if (ctl_q.clear) begin
				wr_pt_q <= '0;
			end else if (bc_v_q) begin
				wr_pt_q <= wr_pt_q + 1'b1;
			end
		end
	end

	assign shift_ok  = CMP_W'(ch_sh[MAX_CLUSTERS]) <= CMP_W'(thr_q);
	assign iter_next = iter_q + 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			iter_q   <= '0;
			conv_q   <= 1'b0;
			ctl_q    <= '0;
			res_v_q  <= 1'b0;
			res_q    <= '0;
			rd_q     <= '0;
			rd_dim_q <= '0;
			iss_v_q  <= 1'b0;
			wait_q   <= '0;
		end else begin
			ctl_q   <= '0;
			res_v_q <= 1'b0;
			iss_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.command)
							kmc_pkg::CMD_READ: begin
								state_q <= S_READ;
							end
							kmc_pkg::CMD_RUN: begin
								iter_q <= '0;
								conv_q <= 1'b0;
								if (maxit_q == '0) begin
									res_v_q <= 1'b1;
									res_q   <= '0;
								end else begin
									state_q <= S_CLEAR;
								end
							end
							kmc_pkg::CMD_LOAD_CENT, kmc_pkg::CMD_LOAD_POINT: begin
								res_v_q <= 1'b1;
								res_q   <= '{label: 3'd0, iterations_used: iter_q,
									converged: conv_q};
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_READ: begin
					res_v_q <= 1'b1;
					res_q   <= '{label: in_range_q ? 3'(lbl_rd_q) : 3'd0,
						iterations_used: iter_q, converged: conv_q};
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					ctl_q.clear <= 1'b1;
					rd_q        <= '0;
					rd_dim_q    <= '0;
					state_q     <= S_ASSIGN;
				end
				S_ASSIGN: begin
					if (rd_q == total) begin
						wait_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						iss_v_q  <= 1'b1;
						rd_q     <= rd_q + 1'b1;
						rd_dim_q <= (rd_dim_q == DIM_W'(DIMENSIONS - 1)) ?
							'0 : rd_dim_q + 1'b1;
					end
				end
				S_DRAIN: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == WT_W'(DRAIN)) begin
						ctl_q.div_start <= 1'b1;
						state_q         <= S_DIV;
					end
				end
				S_DIV: begin
					if (&cell_done) begin
						wait_q  <= '0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == WT_W'(SHCYC)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					iter_q <= iter_next;
					if (shift_ok) begin
						conv_q  <= 1'b1;
						res_v_q <= 1'b1;
						res_q   <= '{label: 3'd0, iterations_used: iter_next,
							converged: 1'b1};
						state_q <= S_IDLE;
					end else begin
						ctl_q.update <= 1'b1;
						if (iter_next == maxit_q) begin
							res_v_q <= 1'b1;
							res_q   <= '{label: 3'd0, iterations_used: iter_next,
								converged: 1'b0};
							state_q <= S_IDLE;
						end else begin
							state_q <= S_CLEAR;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

`ifndef SYNTH
	a_load_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.command == kmc_pkg::CMD_LOAD_POINT |=> result_valid)
		else $error("load word without result");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_cells_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (&cell_done || ~|cell_done))
		else $error("cells out of step in divide");

	a_conv_counts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.converged |-> result.iterations_used != 8'd0)
		else $error("converged with no iteration");

	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && busy |-> $past(state_q == S_IDLE))
		else $error("result while a run is active");
`endif

endmodule

>>> hdl/kmc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_cell
// One cluster of the chain: holds a centroid, its running sums and count,
// scores each passing point and hands the best match on to its neighbor.
// ----------------------------------------------------------------------------
module kmc_cell #(
	parameter int DIMENSIONS = kmc_pkg::DIMENSIONS_DEF,
	parameter int CELL_ID    = 0,
	parameter int IDX_W      = 3,
	parameter int DIM_W      = 2,
	parameter int DIST_W     = 35,
	parameter int CNT_W      = 11,
	parameter int SUM_W      = 27,
	parameter int SH_W       = 38
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kmc_pkg::ctl_t              ctl,
	input  logic                       en,
	input  logic                       ld_v,
	input  logic [IDX_W-1:0]           ld_cell,
	input  logic [DIM_W-1:0]           ld_dim,
	input  logic signed [15:0]         ld_x,
	input  logic                       v_in,
	input  logic signed [15:0]         x_in,
	input  logic [DIM_W-1:0]           dim_in,
	input  logic                       last_in,
	input  logic [DIST_W-1:0]          bd_in,
	input  logic [IDX_W-1:0]           bi_in,
	output logic                       v_out,
	output logic signed [15:0]         x_out,
	output logic [DIM_W-1:0]           dim_out,
	output logic                       last_out,
	output logic [DIST_W-1:0]          bd_out,
	output logic [IDX_W-1:0]           bi_out,
	input  logic                       bc_v,
	input  logic [IDX_W-1:0]           bc_idx,
	input  logic [DIMENSIONS*16-1:0]   bc_x,
	input  logic [SH_W-1:0]            sh_in,
	output logic [SH_W-1:0]            sh_out,
	output logic                       done
);

	localparam int BIT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		DV_IDLE, DV_LOAD, DV_STEP, DV_FIX, DV_SQ, DV_ACC, DV_DONE
	} dv_state_t;

	logic signed [15:0]      cent_q [DIMENSIONS];
	logic signed [15:0]      new_q  [DIMENSIONS];
	logic signed [SUM_W-1:0] sum_q  [DIMENSIONS];
	logic [CNT_W-1:0]        cnt_q;

	logic                    v_s1, last_s1, v_s2, last_s2;
	logic signed [15:0]      x_s1, x_s2;
	logic [DIM_W-1:0]        dim_s1, dim_s2;
	logic [DIST_W-1:0]       bd_s1, bd_s2, acc_q, tot;
	logic [IDX_W-1:0]        bi_s1, bi_s2;
	logic signed [16:0]      diff_s1;
	logic signed [33:0]      prod;
	logic [31:0]             sq_s2;
	logic                    win;

	dv_state_t               dv_q;
	logic [DIM_W-1:0]        ddim_q;
	logic [SUM_W-1:0]        mag_q, quo_q, qs;
	logic                    neg_q;
	logic [CNT_W-1:0]        rem_q;
	logic [BIT_W-1:0]        bit_q;
	logic [CNT_W:0]          trial;
	logic                    ge;
	logic signed [15:0]      newval;
	logic signed [16:0]      dsh_q;
	logic signed [33:0]      dprod;
	logic [31:0]             dsq_q;
	logic [SH_W-1:0]         own_q, sh_q;

	// score the point against this centroid
	assign prod = diff_s1 * diff_s1;
	assign tot  = acc_q + DIST_W'(sq_s2);
	assign win  = en && (tot < bd_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_out <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_out <= v_s2;
			if (v_s2) begin
				acc_q <= last_s2 ? '0 : tot;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= x_in;
		dim_s1   <= dim_in;
		last_s1  <= last_in;
		bd_s1    <= bd_in;
		bi_s1    <= bi_in;
		diff_s1  <= 17'(x_in) - 17'(cent_q[dim_in]);
		x_s2     <= x_s1;
		dim_s2   <= dim_s1;
		last_s2  <= last_s1;
		bd_s2    <= bd_s1;
		bi_s2    <= bi_s1;
		sq_s2    <= prod[31:0];
		x_out    <= x_s2;
		dim_out  <= dim_s2;
		last_out <= last_s2;
		bd_out   <= (last_s2 && win) ? tot : bd_s2;
		bi_out   <= (last_s2 && win) ? IDX_W'(CELL_ID) : bi_s2;
	end

	// accumulate the points assigned to this cluster
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			cnt_q <= '0;
			for (int d = 0; d < DIMENSIONS; d++) begin
				sum_q[d] <= '0;
			end
		end else if (bc_v && bc_idx == IDX_W'(CELL_ID)) begin
			cnt_q <= cnt_q + 1'b1;
			for (int d = 0; d < DIMENSIONS; d++) begin
				sum_q[d] <= sum_q[d] + SUM_W'($signed(bc_x[d*16 +: 16]));
			end
		end
	end

	// centroid: update from the averages, then loads take priority
	always_ff @(posedge clk) begin
		if (ctl.update && en) begin
			for (int d = 0; d < DIMENSIONS; d++) begin
				cent_q[d] <= new_q[d];
			end
		end
		if (ld_v && ld_cell == IDX_W'(CELL_ID)) begin
			cent_q[ld_dim] <= ld_x;
		end
	end

	// restoring divide step and shift terms
	assign trial  = {rem_q, mag_q[SUM_W-1]};
	assign ge     = trial >= {1'b0, cnt_q};
	assign qs     = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign newval = (cnt_q == '0) ? 16'sd0 : $signed(qs[15:0]);
	assign dprod  = dsh_q * dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q   <= DV_IDLE;
			ddim_q <= '0;
			mag_q  <= '0;
			quo_q  <= '0;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			bit_q  <= '0;
			dsh_q  <= '0;
			dsq_q  <= '0;
			own_q  <= '0;
			for (int d = 0; d < DIMENSIONS; d++) begin
				new_q[d] <= '0;
			end
		end else if (ctl.clear) begin
			dv_q <= DV_IDLE;
		end else if (ctl.div_start) begin
			dv_q   <= DV_LOAD;
			ddim_q <= '0;
			own_q  <= '0;
		end else begin
			unique case (dv_q)
				DV_LOAD: begin
					neg_q <= sum_q[ddim_q][SUM_W-1];
					mag_q <= sum_q[ddim_q][SUM_W-1] ? SUM_W'(-sum_q[ddim_q]) : sum_q[ddim_q];
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= BIT_W'(SUM_W - 1);
					dv_q  <= DV_STEP;
				end
				DV_STEP: begin
					rem_q <= ge ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
					quo_q <= {quo_q[SUM_W-2:0], ge};
					mag_q <= {mag_q[SUM_W-2:0], 1'b0};
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						dv_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					new_q[ddim_q] <= newval;
					dsh_q <= 17'(cent_q[ddim_q]) - 17'(newval);
					dv_q  <= DV_SQ;
				end
				DV_SQ: begin
					dsq_q <= dprod[31:0];
					dv_q  <= DV_ACC;
				end
				DV_ACC: begin
					if (en) begin
						own_q <= own_q + SH_W'(dsq_q);
					end
					ddim_q <= ddim_q + 1'b1;
					dv_q   <= (ddim_q == DIM_W'(DIMENSIONS - 1)) ? DV_DONE : DV_LOAD;
				end
				DV_IDLE, DV_DONE: begin
					dv_q <= dv_q;
				end
				default: dv_q <= DV_IDLE;
			endcase
		end
	end

	// running total of the shift along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
		end else begin
			sh_q <= sh_in + own_q;
		end
	end

	assign sh_out = sh_q;
	assign done   = (dv_q == DV_DONE);

endmodule

>>> tb/sv/kmeans_clustering_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_clustering_engine_test
// Drives load, run and read commands into the k-means engine in bursts,
// predicts every result word with a local fixed-point Lloyd model and checks
// each strobed result against it. Settings of k, the iteration limit and the
// threshold change between phases, their extremes included.
// ----------------------------------------------------------------------------
module kmeans_clustering_engine_test;

	localparam int NPTS  = kmc_pkg::MAX_POINTS_DEF;
	localparam int NDIM  = kmc_pkg::DIMENSIONS_DEF;
	localparam int NCL   = kmc_pkg::MAX_CLUSTERS_DEF;
	localparam int PWORDS = NPTS * NDIM;
	localparam int CWORDS = NCL * NDIM;
	localparam int WATCHDOG = 4000000;

	int n_errors;

	task automatic report_mismatch(string what, longint e, longint g);
		n_errors++;
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, e, g, $realtime);
	endtask

	// label predictor and queue of expected result words
	class kmeans_scoreboard;
		logic signed [15:0] pts[PWORDS];
		logic signed [15:0] cents[CWORDS];
		logic [2:0]         labels[NPTS];
		int                 n_points, load_pos, cent_pos;
		logic [7:0]         iters;
		logic               conv;
		logic [3:0]         k_reg;
		logic [7:0]         iter_lim;
		logic [39:0]        thr;
		kmc_pkg::result_t   pending[$];
		int                 checked, runs, runs_conv;

		function void init();
			n_points = 0; load_pos = 0; cent_pos = 0; iters = 0; conv = 0;
			k_reg = kmc_pkg::NUM_CLUSTERS_RST;
			iter_lim = kmc_pkg::MAX_ITER_RST;
			thr = kmc_pkg::THRESHOLD_RST;
			checked = 0; runs = 0; runs_conv = 0;
			foreach (labels[i]) labels[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [39:0] d);
			if (idx == kmc_pkg::CFG_NUM_CLUSTERS) k_reg = d[3:0];
			else if (idx == kmc_pkg::CFG_MAX_ITER) iter_lim = d[7:0];
			else if (idx == kmc_pkg::CFG_THRESHOLD) thr = d;
		endfunction

		function longint unsigned dist2(longint a[NDIM], longint b[NDIM]);
			longint unsigned s;
			s = 0;
			for (int d = 0; d < NDIM; d++) s += (a[d] - b[d]) * (a[d] - b[d]);
			return s;
		endfunction

		function void cluster_run();
			int k, best;
			longint pv[NDIM], cv[NCL][NDIM], nv[NCL][NDIM], sums[NCL][NDIM];
			int cnt[NCL];
			longint unsigned bd, dd, shift;
			k = (k_reg == 0) ? 1 : (k_reg > NCL ? NCL : k_reg);
			iters = 0; conv = 0; runs++;
			for (int c = 0; c < NCL; c++)
				for (int d = 0; d < NDIM; d++) cv[c][d] = cents[c*NDIM+d];
			for (int it = 0; it < iter_lim; it++) begin
				shift = 0;
				for (int c = 0; c < NCL; c++) begin
					cnt[c] = 0;
					for (int d = 0; d < NDIM; d++) sums[c][d] = 0;
				end
				for (int p = 0; p < n_points; p++) begin
					for (int d = 0; d < NDIM; d++) pv[d] = pts[p*NDIM+d];
					best = 0; bd = dist2(pv, cv[0]);
					for (int c = 1; c < k; c++) begin
						dd = dist2(pv, cv[c]);
						if (dd < bd) begin bd = dd; best = c; end
					end
					labels[p] = best;
					for (int d = 0; d < NDIM; d++) sums[best][d] += pv[d];
					cnt[best]++;
				end
				for (int c = 0; c < k; c++) begin
					// integer division truncates toward zero
					for (int d = 0; d < NDIM; d++)
						nv[c][d] = cnt[c] > 0 ? sums[c][d] / cnt[c] : 0;
					shift += dist2(cv[c], nv[c]);
				end
				iters = it + 1;
				if (shift <= thr) begin conv = 1; runs_conv++; break; end
				for (int c = 0; c < k; c++) cv[c] = nv[c];
			end
			for (int c = 0; c < NCL; c++)
				for (int d = 0; d < NDIM; d++) cents[c*NDIM+d] = cv[c][d];
		endfunction

		// note an accepted command word and queue its result
		function void note_item(kmc_pkg::item_t it);
			kmc_pkg::result_t r;
			r = '0;
			case (it.command)
				kmc_pkg::CMD_LOAD_CENT: begin
					cents[cent_pos] = it.value;
					cent_pos = (cent_pos + 1) % CWORDS;
				end
				kmc_pkg::CMD_LOAD_POINT: begin
					if (load_pos < PWORDS) begin
						pts[load_pos] = it.value; load_pos++;
					end
					if (it.last_point) begin
						n_points = (load_pos + NDIM - 1) / NDIM;
						load_pos = 0;
					end
				end
				kmc_pkg::CMD_RUN: begin
					cent_pos = 0;
					cluster_run();
				end
				kmc_pkg::CMD_READ: r.label = labels[it.point_index];
			endcase
			r.iterations_used = iters;
			r.converged = conv;
			pending.push_back(r);
		endfunction

		task check(kmc_pkg::result_t got);
			kmc_pkg::result_t e;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("result with no expectation", 0, got);
				return;
			end
			e = pending.pop_front();
			if (got.label !== e.label)
				report_mismatch("label", e.label, got.label);
			if (got.iterations_used !== e.iterations_used)
				report_mismatch("iterations_used", e.iterations_used, got.iterations_used);
			if (got.converged !== e.converged)
				report_mismatch("converged", e.converged, got.converged);
		endtask
	endclass

	logic       clk, arst_n, start, busy, result_valid, cfg_valid, cfg_ready;
	kmc_pkg::item_t   item;
	kmc_pkg::result_t result;
	logic [1:0] cfg_index;
	logic [39:0] cfg_data;

	kmeans_scoreboard sb;
	int idle_cycles;
	int written_points;   // points whose labels may be read

	kmeans_clustering_engine u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// check every strobed result word
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check(result);
	end

	// watchdog on cycles with no accepted word, config write or result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Watchdog expired");
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send(kmc_pkg::cmd_t c, logic [15:0] v, logic [9:0] idx, logic lp);
		kmc_pkg::item_t it;
		it.command = c; it.value = v; it.point_index = idx; it.last_point = lp;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
	endtask

	// sometimes close a burst: lower start and idle for a random gap
	task automatic gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] d);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_centroids(int mag);
		for (int i = 0; i < CWORDS; i++) begin
			send(kmc_pkg::CMD_LOAD_CENT, 16'($signed($urandom_range(0, 2*mag)) - mag),
				10'($urandom), 1'($urandom));
			gap();
		end
	endtask

	// load n points clustered around four centers spaced mag apart
	task automatic load_points(int n, int mag);
		int cx;
		for (int p = 0; p < n; p++) begin
			cx = $urandom_range(0, 3);
			for (int d = 0; d < NDIM; d++) begin
				send(kmc_pkg::CMD_LOAD_POINT,
					16'((cx - 2) * mag + $signed($urandom_range(0, mag/2)) - mag/4),
					10'($urandom), (p == n - 1 && d == NDIM - 1));
				gap();
			end
		end
		if (n > written_points) written_points = n;
	endtask

	task automatic read_labels(int n);
		for (int i = 0; i < n; i++) begin
			send(kmc_pkg::CMD_READ, 16'($urandom),
				10'($urandom_range(0, written_points - 1)), 1'($urandom));
			gap();
		end
	endtask

	int items_sent;

	initial begin
		sb = new();
		sb.init();
		n_errors = 0;
		arst_n = 0; start = 0; item = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		idle_cycles = 0; written_points = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme coordinates, all commands, k of one, zero limit
		write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 40'd1);
		write_reg(kmc_pkg::CFG_MAX_ITER, 40'd0);
		write_reg(kmc_pkg::CFG_THRESHOLD, 40'd0);
		for (int i = 0; i < CWORDS; i++)
			send(kmc_pkg::CMD_LOAD_CENT, (i % 2) ? 16'h8000 : 16'h7fff, 10'h3ff, 1'b1);
		// fill two whole points so the partial point below sees only written words
		for (int i = 0; i < 2 * NDIM; i++)
			send(kmc_pkg::CMD_LOAD_POINT, 16'(i * 'h1234), 10'd0, i == 2 * NDIM - 1);
		send(kmc_pkg::CMD_LOAD_POINT, 16'h7fff, 10'd0, 1'b0);
		send(kmc_pkg::CMD_LOAD_POINT, 16'h8000, 10'd0, 1'b0);
		send(kmc_pkg::CMD_LOAD_POINT, 16'hffff, 10'd0, 1'b0);
		send(kmc_pkg::CMD_LOAD_POINT, 16'h0000, 10'd0, 1'b0);
		send(kmc_pkg::CMD_LOAD_POINT, 16'h0100, 10'd0, 1'b1);  // partial second point
		written_points = 2;
		send(kmc_pkg::CMD_RUN, 16'h0, 10'd0, 1'b0);       // no iterations
		drain();
		write_reg(kmc_pkg::CFG_MAX_ITER, 40'd1);
		send(kmc_pkg::CMD_RUN, 16'h0, 10'd0, 1'b0);
		send(kmc_pkg::CMD_READ, 16'h0, 10'd0, 1'b0);
		send(kmc_pkg::CMD_READ, 16'h0, 10'd1, 1'b0);
		drain();
		// cluster count above range acts as the maximum
		write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 40'd15);
		write_reg(kmc_pkg::CFG_MAX_ITER, 40'd255);
		write_reg(kmc_pkg::CFG_THRESHOLD, 40'hff_ffff_ffff);
		send(kmc_pkg::CMD_RUN, 16'h0, 10'd0, 1'b0);
		send(kmc_pkg::CMD_READ, 16'h0, 10'd1, 1'b0);
		drain();
		items_sent = 51;

		// random phases with small point sets and changing settings
		for (int ph = 0; items_sent < 1700; ph++) begin
			int np, mag;
			case (ph % 4)
				0: write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 40'($urandom_range(0, 15)));
				1: write_reg(kmc_pkg::CFG_MAX_ITER,
					ph % 3 == 0 ? 40'd255 : 40'($urandom_range(1, 20)));
				2: write_reg(kmc_pkg::CFG_THRESHOLD,
					ph % 3 == 0 ? 40'd0 : 40'($urandom_range(0, 8000000)));
				default: write_reg(kmc_pkg::CFG_NUM_CLUSTERS, ph % 8 == 3 ? 40'd8 : 40'd0);
			endcase
			np = $urandom_range(0, 12) == 0 ? $urandom_range(60, 120) : $urandom_range(1, 16);
			mag = $urandom_range(0, 1) ? 16000 : $urandom_range(64, 4000);
			load_centroids(mag);
			load_points(np, mag);
			send(kmc_pkg::CMD_RUN, 16'($urandom), 10'($urandom), 1'($urandom));
			read_labels(np < 10 ? np : 10);
			items_sent += CWORDS + np * NDIM + 1 + (np < 10 ? np : 10);
			drain();
		end

		if (sb.pending.size() != 0)
			report_mismatch("results never arrived", sb.pending.size(), 0);
		$display("Checked %0d results over %0d runs, %0d of them converged.",
			sb.checked, sb.runs, sb.runs_conv);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hdl/kmc_pkg.sv
hdl/kmc_cell.sv
hdl/kmeans_clustering_engine.sv
tb/sv/kmeans_clustering_engine_test.sv
